FILE: hw/rtl/cil_pkg.sv
package cil_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int OPW = 2;
  localparam int IDXW = 7;
  localparam int DW = 32;
  localparam int CNTW = 7;

  typedef enum logic [OPW-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic shift;
    logic put;
    logic rd_idx;
    logic result;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic ins_ok;
    logic rem_ok;
    logic at_end;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hw/rtl/cil_ram.sv
module cil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/cil_ctrl.sv
module cil_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cil_pkg::dp_stat_t   stat,
  output cil_pkg::ctrl_cmd_t  cmd
);

  import cil_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_PUT   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.op)
          OP_INSERT: state_nxt = stat.ins_ok ? S_SHIFT : S_DONE;
          OP_REMOVE: state_nxt = stat.rem_ok ? S_SHIFT : S_DONE;
          OP_READ: begin
            cmd.rd_idx = stat.rem_ok;
            state_nxt  = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.at_end) begin
          state_nxt = (stat.op == OP_INSERT) ? S_PUT : S_DONE;
        end
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.result = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/cil_dp.sv
module cil_dp #(
  parameter int CAPACITY = cil_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [cil_pkg::OPW-1:0]       in_operation,
  input  logic [cil_pkg::IDXW-1:0]      in_index,
  input  logic signed [cil_pkg::DW-1:0] in_value,
  input  cil_pkg::ctrl_cmd_t            cmd,
  output cil_pkg::dp_stat_t             stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_ok,
  output logic signed [cil_pkg::DW-1:0] out_read_value,
  output logic [cil_pkg::CNTW-1:0]      out_count
);

  import cil_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (LW > IDXW) ? LW : IDXW;

  op_t               op_r;
  logic [IDXW-1:0]   idx_r;
  logic [DW-1:0]     val_r;
  logic [LW-1:0]     len_r;
  logic [LW-1:0]     len_nxt;
  logic [LW-1:0]     ptr_r;
  logic              pend_r;
  logic [AW-1:0]     pend_addr_r;

  logic              out_valid_r;
  logic              out_ok_r;
  logic [DW-1:0]     out_rd_r;
  logic [CNTW-1:0]   out_count_r;

  logic [CW-1:0]     idx_c;
  logic [CW-1:0]     len_c;
  logic [CW-1:0]     ptr_c;
  logic              ins_ok;
  logic              rem_ok;
  logic              at_end;
  logic              out_free;
  logic              res_ok;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DW-1:0]     ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DW-1:0]     ram_rdata;
  logic [AW-1:0]     src_addr;

  assign idx_c = CW'(idx_r);
  assign len_c = CW'(len_r);
  assign ptr_c = CW'(ptr_r);

  assign ins_ok = (len_r < LW'(CAPACITY)) && (idx_c <= len_c);
  assign rem_ok = idx_c < len_c;

  // Insert moves entries up from the tail down to the index; remove moves
  // them down from the index up to the tail.
  assign at_end = (op_r == OP_INSERT) ? (ptr_c == idx_c) : (ptr_c == len_c - CW'(1));
  assign src_addr = (op_r == OP_INSERT) ? AW'(ptr_r - LW'(1)) : AW'(ptr_r + LW'(1));

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    stat          = '0;
    stat.op       = op_r;
    stat.ins_ok   = ins_ok;
    stat.rem_ok   = rem_ok;
    stat.at_end   = at_end;
    stat.out_free = out_free;
  end

  // A read issued during one shift step is written one slot over in the next.
  assign ram_re    = cmd.rd_idx || (cmd.shift && !at_end);
  assign ram_raddr = cmd.rd_idx ? AW'(idx_r) : src_addr;
  assign ram_we    = (cmd.shift && pend_r) || cmd.put;
  assign ram_waddr = cmd.put ? AW'(idx_r) : pend_addr_r;
  assign ram_wdata = cmd.put ? val_r : ram_rdata;

  cil_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    len_nxt = len_r;
    res_ok  = 1'b0;
    case (op_r)
      OP_INSERT: begin
        res_ok = ins_ok;
        if (ins_ok) begin
          len_nxt = len_r + LW'(1);
        end
      end
      OP_REMOVE: begin
        res_ok = rem_ok;
        if (rem_ok) begin
          len_nxt = len_r - LW'(1);
        end
      end
      OP_READ: res_ok = rem_ok;
      default: begin
        res_ok  = 1'b1;
        len_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_operation);
      idx_r <= in_index;
      val_r <= in_value;
      if (op_t'(in_operation) == OP_INSERT) begin
        ptr_r <= len_r;
      end else begin
        ptr_r <= LW'(CW'(in_index));
      end
    end else if (cmd.shift && !at_end) begin
      ptr_r <= (op_r == OP_INSERT) ? ptr_r - LW'(1) : ptr_r + LW'(1);
    end
    if (cmd.shift) begin
      pend_addr_r <= AW'(ptr_r);
    end
    if (cmd.result) begin
      out_ok_r    <= res_ok;
      out_rd_r    <= (op_r == OP_READ && rem_ok) ? ram_rdata : '0;
      out_count_r <= CNTW'(len_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        pend_r <= 1'b0;
      end else if (cmd.shift) begin
        pend_r <= !at_end;
      end
      if (cmd.result) begin
        len_r       <= len_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_rd_r;
  assign out_count      = out_count_r;

endmodule

FILE: hw/rtl/indexed_insert_delete_list.sv
// Sequence: read and clear pass the load, execute and done states; a successful
// insert or remove also shifts between index and tail, insert then a put step;
// while shifting, the entry RAM reads one entry and writes one entry per cycle.
// Throughput: one item at a time; the next item is taken once the result is
// registered, even while that result waits on the output.
// Reset: synchronous, active low; empties the list, entry RAM is not cleared.
module indexed_insert_delete_list #(
  parameter int CAPACITY = cil_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cil_pkg::OPW-1:0]       in_operation,
  input  logic [cil_pkg::IDXW-1:0]      in_index,
  input  logic signed [cil_pkg::DW-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_ok,
  output logic signed [cil_pkg::DW-1:0] out_read_value,
  output logic [cil_pkg::CNTW-1:0]      out_count
);

  import cil_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  cil_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cil_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_operation   (in_operation),
    .in_index       (in_index),
    .in_value       (in_value),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ok         (out_ok),
    .out_read_value (out_read_value),
    .out_count      (out_count)
  );

  // The controller issues at most one datapath command per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.shift, cmd.put, cmd.rd_idx, cmd.result}))
    else $error("more than one datapath command in a cycle");

  // A failed operation never returns data.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_read_value == '0))
    else $error("failed operation returned a nonzero value");

  // The reported count stays within the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_count) <= CAPACITY))
    else $error("count exceeds capacity");

  // A new item is taken only when no command is already in flight.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !cmd.load && !cmd.result)
    else $error("item loaded while one is in progress");

endmodule
